>>> sv/modexp_pkg.sv
// Shared types and constants of the modular exponentiation block.
`default_nettype none

package modexp_pkg;

    // Widths of the external ports, fixed by the item and register formats.
    localparam int MSG_W      = 32;
    localparam int CFG_DATA_W = 32;
    localparam int CFG_IDX_W  = 2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_MODULUS  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_EXPONENT = 2'd1;

    // Sequencer states of the exponentiation loop.
    typedef enum logic [2:0] {
        ME_IDLE,
        ME_ACC_GO,
        ME_ACC_WAIT,
        ME_SQR_GO,
        ME_SQR_WAIT,
        ME_FINISH
    } me_state_t;

    // States of the shared multiply and reduce unit.
    typedef enum logic {
        MM_IDLE,
        MM_RED
    } mm_state_t;

endpackage

`default_nettype wire

>>> sv/modexp_mulmod.sv
// Shared modular multiplier: one registered product, then a two-bit-per-cycle reduction.
`default_nettype none

module modexp_mulmod #(
    parameter int WORD_BITS = 32
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    input  wire logic [WORD_BITS-1:0] a,
    input  wire logic [WORD_BITS-1:0] b,
    input  wire logic [WORD_BITS-1:0] n,
    output logic                      done,
    output logic [WORD_BITS-1:0]      result
);
    import modexp_pkg::*;

    localparam int PROD_W = 2 * WORD_BITS;
    localparam int CNT_W  = $clog2(WORD_BITS);

    mm_state_t              state_reg;
    mm_state_t              state_next;
    logic [CNT_W-1:0]       cnt_reg;
    logic                   done_reg;
    logic [PROD_W-1:0]      prod_reg;
    logic [WORD_BITS-1:0]   rem_reg;

    logic [WORD_BITS:0]     t1;
    logic [WORD_BITS:0]     t2;
    logic [WORD_BITS-1:0]   r1;
    logic [WORD_BITS-1:0]   r2;
    logic                   last;
    logic                   n_zero;

    // Two restoring division steps: shift in the next two product bits.
    always_comb
    begin
        t1 = {rem_reg, prod_reg[PROD_W-1]};
        if (t1 >= {1'b0, n})
        begin
            t1 = t1 - {1'b0, n};
        end
        r1 = t1[WORD_BITS-1:0];
        t2 = {r1, prod_reg[PROD_W-2]};
        if (t2 >= {1'b0, n})
        begin
            t2 = t2 - {1'b0, n};
        end
        r2 = t2[WORD_BITS-1:0];
    end

    assign last   = (cnt_reg == CNT_W'(WORD_BITS - 1));
    // A zero modulus stands for 2^WORD_BITS: keep the low half of the product.
    assign n_zero = (n == '0);

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            MM_IDLE:
            begin
                if (start)
                begin
                    state_next = MM_RED;
                end
            end
            MM_RED:
            begin
                if (n_zero || last)
                begin
                    state_next = MM_IDLE;
                end
            end
            default:
            begin
                state_next = MM_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= MM_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= 1'b0;
            if (state_reg == MM_IDLE)
            begin
                cnt_reg <= '0;
            end
            else
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (n_zero || last)
                begin
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Product and partial remainder.
    always_ff @(posedge clk)
    begin
        if (state_reg == MM_IDLE)
        begin
            if (start)
            begin
                prod_reg <= PROD_W'(a) * PROD_W'(b);
                rem_reg  <= '0;
            end
        end
        else if (n_zero)
        begin
            rem_reg <= prod_reg[WORD_BITS-1:0];
        end
        else
        begin
            rem_reg  <= r2;
            prod_reg <= {prod_reg[PROD_W-3:0], 2'b00};
        end
    end

    assign done   = done_reg;
    assign result = rem_reg;

endmodule

`default_nettype wire

>>> sv/modular_exponentiation.sv
// Top level: right-to-left square-and-multiply sequencer around a shared modular multiplier.
//
// Usage. Write the modulus (index 0) and exponent (index 1) through cfg_write, cfg_index and
// cfg_data while the block is idle; other indexes are ignored. Each input item on message
// (in_valid/in_ready) yields one result item on power_mod (out_valid/out_ready).
// The exponent is scanned from its least significant bit. For each set bit the running
// product is multiplied by the base, and the base is squared while higher set bits remain.
// Every modular multiplication runs on the one shared unit: a registered product followed by a
// reduction that retires two product bits per cycle.
// A zero exponent gives 1.
// in_ready is high only while the sequencer is idle: one item is worked on at a time.
// A finished result moves into an output register, so the next item is taken while it waits.
// If the receiver stalls with the output register full, the sequencer holds its result.
// Reset sets the modulus to 2, the exponent to 1 and empties the output register.
// A zero modulus is treated as 2^WORD_BITS.
`default_nettype none

module modular_exponentiation #(
    parameter int WORD_BITS = 32
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cfg_write,
    input  wire logic [modexp_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [modexp_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  wire logic                               in_valid,
    output logic                                    in_ready,
    input  wire logic [modexp_pkg::MSG_W-1:0]       message,
    output logic                                    out_valid,
    input  wire logic                               out_ready,
    output logic [modexp_pkg::MSG_W-1:0]            power_mod
);
    import modexp_pkg::*;

    me_state_t              state_reg;
    me_state_t              state_next;
    logic [WORD_BITS-1:0]   modulus_reg;
    logic [WORD_BITS-1:0]   exponent_reg;
    logic [WORD_BITS-1:0]   acc_reg;
    logic [WORD_BITS-1:0]   base_reg;
    logic [WORD_BITS-1:0]   e_reg;
    logic                   out_valid_reg;
    logic [WORD_BITS-1:0]   out_data_reg;

    logic                   accept;
    logic                   load_out;
    logic                   more_bits;
    logic                   mm_start;
    logic [WORD_BITS-1:0]   mm_a;
    logic                   mm_done;
    logic [WORD_BITS-1:0]   mm_result;

    // Shared modular multiplier.
    modexp_mulmod #(
        .WORD_BITS(WORD_BITS)
    ) u_mulmod (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (mm_start),
        .a      (mm_a),
        .b      (base_reg),
        .n      (modulus_reg),
        .done   (mm_done),
        .result (mm_result)
    );

    assign accept    = in_valid && in_ready;
    assign load_out  = (state_reg == ME_FINISH) && (!out_valid_reg || out_ready);
    // True while exponent bits above the current one are still set.
    assign more_bits = (e_reg[WORD_BITS-1:1] != '0);

    // Next state of the sequencer.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ME_IDLE:
            begin
                if (in_valid)
                begin
                    if (exponent_reg[0])
                    begin
                        state_next = ME_ACC_GO;
                    end
                    else if (exponent_reg == '0)
                    begin
                        state_next = ME_FINISH;
                    end
                    else
                    begin
                        state_next = ME_SQR_GO;
                    end
                end
            end
            ME_ACC_GO:
            begin
                state_next = ME_ACC_WAIT;
            end
            ME_ACC_WAIT:
            begin
                if (mm_done)
                begin
                    state_next = more_bits ? ME_SQR_GO : ME_FINISH;
                end
            end
            ME_SQR_GO:
            begin
                state_next = ME_SQR_WAIT;
            end
            ME_SQR_WAIT:
            begin
                if (mm_done)
                begin
                    state_next = e_reg[1] ? ME_ACC_GO : ME_SQR_GO;
                end
            end
            ME_FINISH:
            begin
                if (load_out)
                begin
                    state_next = ME_IDLE;
                end
            end
            default:
            begin
                state_next = ME_IDLE;
            end
        endcase
    end

    // Sequencer outputs.
    always_comb
    begin
        in_ready = 1'b0;
        mm_start = 1'b0;
        mm_a     = base_reg;
        unique case (state_reg)
            ME_IDLE:
            begin
                in_ready = 1'b1;
            end
            ME_ACC_GO:
            begin
                mm_start = 1'b1;
                mm_a     = acc_reg;
            end
            ME_SQR_GO:
            begin
                mm_start = 1'b1;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    // Control state and the output register's valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ME_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Key registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            modulus_reg  <= WORD_BITS'(2);
            exponent_reg <= WORD_BITS'(1);
        end
        else if (cfg_write)
        begin
            if (cfg_index == REG_MODULUS)
            begin
                modulus_reg <= cfg_data[WORD_BITS-1:0];
            end
            else if (cfg_index == REG_EXPONENT)
            begin
                exponent_reg <= cfg_data[WORD_BITS-1:0];
            end
        end
    end

    // Working values of the exponentiation and the result register.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            base_reg <= message[WORD_BITS-1:0];
            e_reg    <= exponent_reg;
            acc_reg  <= WORD_BITS'(1);
        end
        if ((state_reg == ME_ACC_WAIT) && mm_done)
        begin
            acc_reg <= mm_result;
        end
        if ((state_reg == ME_SQR_WAIT) && mm_done)
        begin
            base_reg <= mm_result;
            e_reg    <= {1'b0, e_reg[WORD_BITS-1:1]};
        end
        if (load_out)
        begin
            out_data_reg <= acc_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign power_mod = MSG_W'(out_data_reg);

    // The multiplier only finishes while the sequencer waits for it.
    a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        mm_done |-> (state_reg == ME_ACC_WAIT || state_reg == ME_SQR_WAIT))
        else $error("multiplier finished outside a wait state");

    // A reduced product is below a nonzero modulus.
    a_reduced: assert property (@(posedge clk) disable iff (!rst_n)
        (mm_done && modulus_reg != '0) |-> (mm_result < modulus_reg))
        else $error("reduction result not below the modulus");

    // A squaring is only issued while higher exponent bits remain.
    a_square_needed: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ME_SQR_GO) |-> more_bits)
        else $error("squaring issued with no exponent bits left");

    // An accepted item keeps the block busy in the next cycle.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !in_ready)
        else $error("block ready right after accepting an item");

endmodule

`default_nettype wire

>>> verif/tb_top.sv
// Self-checking testbench for the modular exponentiation block, with its own power predictor.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import modexp_pkg::*;

    // Register indexes that the block has to ignore.
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

    // Cycles that one item can take at most, with some margin.
    localparam int ITEM_CYCLES = 2200;

    typedef struct {
        logic [MSG_W-1:0] message;
        logic [MSG_W-1:0] power_mod;
    } power_item_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_write;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  in_valid;
    logic                  in_ready;
    logic [MSG_W-1:0]      message;
    logic                  out_valid;
    logic                  out_ready;
    logic [MSG_W-1:0]      power_mod;

    // Predictor copy of the key registers.
    logic [MSG_W-1:0] key_modulus;
    logic [MSG_W-1:0] key_exponent;

    logic [MSG_W-1:0] message_q[$];
    power_item_t      power_q[$];

    int  queued_count;
    int  accepted_count;
    int  checked_count;
    int  mismatch_count;
    int  fail_count;
    int  key_count;
    int  send_gap;
    int  ready_gap;
    bit  idling_on;

    modular_exponentiation #(
        .WORD_BITS (32)
    ) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .message   (message),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .power_mod (power_mod)
    );

    // Clock generation.
    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    // Reduce a double-width product; a zero modulus stands for 2^32.
    function automatic logic [63:0] reduce_product(input logic [63:0] product,
                                                   input logic [MSG_W-1:0] n);
        if (n == '0)
            return {32'd0, product[31:0]};
        return product % {32'd0, n};
    endfunction

    // Right-to-left square-and-multiply over the exponent bits.
    function automatic logic [MSG_W-1:0] mod_power(input logic [MSG_W-1:0] base_in,
                                                   input logic [MSG_W-1:0] n,
                                                   input logic [MSG_W-1:0] e_in);
        logic [63:0]      acc;
        logic [63:0]      base;
        logic [MSG_W-1:0] e;
        acc  = 64'd1;
        base = {32'd0, base_in};
        e    = e_in;
        for (int i = 0; i < MSG_W && e != '0; i++)
        begin
            if (e[0])
                acc = reduce_product(acc * base, n);
            base = reduce_product(base * base, n);
            e = e >> 1;
        end
        return acc[MSG_W-1:0];
    endfunction

    // Input driver: takes items from the pending queue, with random gaps.
    always @(posedge clk)
    begin
        bit busy;
        power_item_t item;
        busy = in_valid;
        if (in_valid && in_ready)
        begin
            item.message   = message;
            item.power_mod = mod_power(message, key_modulus, key_exponent);
            power_q.push_back(item);
            accepted_count++;
            busy = 1'b0;
        end
        if (!busy)
        begin
            if (send_gap > 0)
            begin
                send_gap--;
                in_valid <= 1'b0;
            end
            else if (message_q.size() > 0 && idling_on && $urandom_range(0, 5) == 0)
            begin
                send_gap = $urandom_range(1, 11) - 1;
                in_valid <= 1'b0;
            end
            else if (message_q.size() > 0)
            begin
                in_valid <= 1'b1;
                message  <= message_q.pop_front();
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // Output monitor: checks each result item and stalls the receiver at random.
    always @(posedge clk)
    begin
        power_item_t item;
        if (out_valid === 1'b1 && out_ready)
        begin
            if (power_q.size() == 0)
            begin
                fail_count++;
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("Unexpected result item: power_mod %h", power_mod);
            end
            else
            begin
                item = power_q.pop_front();
                checked_count++;
                if (power_mod !== item.power_mod)
                begin
                    fail_count++;
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("power_mod mismatch for message %h: expected %h, got %h",
                                 item.message, item.power_mod, power_mod);
                end
            end
        end
        if (ready_gap > 0)
        begin
            ready_gap--;
            out_ready <= 1'b0;
        end
        else if (idling_on && $urandom_range(0, 7) == 0)
        begin
            ready_gap = $urandom_range(1, 11) - 1;
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= 1'b1;
        end
    end

    // Write one register; consecutive writes keep the enable high.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        if (idx == REG_MODULUS)
            key_modulus = value;
        else if (idx == REG_EXPONENT)
            key_exponent = value;
    endtask

    task automatic set_key(input logic [MSG_W-1:0] n, input logic [MSG_W-1:0] e);
        write_reg(REG_MODULUS, n);
        write_reg(REG_EXPONENT, e);
        @(posedge clk);
        cfg_write <= 1'b0;
        key_count++;
    endtask

    task automatic send_message(input logic [MSG_W-1:0] value);
        message_q.push_back(value);
        queued_count++;
    endtask

    // Wait until every queued item has been taken and every result has arrived.
    task automatic wait_drained();
        while (!(accepted_count == queued_count && power_q.size() == 0))
            @(posedge clk);
        @(posedge clk);
    endtask

    // One key setting with random messages.
    task automatic run_random_key(input int count);
        logic [MSG_W-1:0] n;
        logic [MSG_W-1:0] e;
        logic [MSG_W-1:0] m;
        case ($urandom_range(0, 11))
            0: n = 32'd2;
            1: n = 32'hFFFF_FFFF;
            2: n = $urandom_range(3, 255);
            3: n = $urandom_range(0, 1);
            4: n = $urandom_range(256, 65535);
            default: n = $urandom;
        endcase
        case ($urandom_range(0, 11))
            0: e = '0;
            1: e = 32'hFFFF_FFFF;
            2: e = 32'd65537;
            3: e = $urandom_range(1, 15);
            4: e = 32'h8000_0000 | $urandom_range(0, 255);
            default: e = $urandom;
        endcase
        // Spare indexes are written with random data now and then; the block ignores them.
        if ($urandom_range(0, 2) == 0)
            write_reg(REG_SPARE_2, $urandom);
        set_key(n, e);
        if ($urandom_range(0, 2) == 0)
        begin
            write_reg(REG_SPARE_3, $urandom);
            @(posedge clk);
            cfg_write <= 1'b0;
        end
        repeat (count)
        begin
            case ($urandom_range(0, 9))
                0: m = '0;
                1: m = 32'hFFFF_FFFF;
                2: m = n - 1;
                3: m = n + $urandom_range(0, 3);
                default: m = $urandom;
            endcase
            send_message(m);
        end
        wait_drained();
    endtask

    // Main sequence: reset, directed keys, then random keys.
    initial
    begin
        rst_n        = 1'b0;
        cfg_write    = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        in_valid     = 1'b0;
        message      = '0;
        out_ready    = 1'b0;
        key_modulus  = 32'd2;
        key_exponent = 32'd1;
        queued_count   = 0;
        accepted_count = 0;
        checked_count  = 0;
        mismatch_count = 0;
        fail_count     = 0;
        key_count      = 1;
        send_gap       = 0;
        ready_gap      = 0;
        idling_on      = 1'b1;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset key values: modulus 2, exponent 1.
        send_message(32'd0);
        send_message(32'd1);
        send_message(32'hFFFF_FFFF);
        send_message(32'd3);
        wait_drained();

        // Largest modulus and exponent.
        set_key(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_message(32'd0);
        send_message(32'd1);
        send_message(32'd2);
        send_message(32'hFFFF_FFFF);
        send_message(32'hFFFF_FFFE);
        wait_drained();

        // Zero exponent gives one regardless of the message.
        set_key(32'd13, 32'd0);
        send_message(32'd0);
        send_message(32'd5);
        send_message(32'hFFFF_FFFF);
        wait_drained();

        // Modulus one reduces everything to zero, except with a zero exponent.
        set_key(32'd1, 32'h0001_2345);
        send_message(32'd7);
        send_message(32'hFFFF_FFFF);
        wait_drained();
        set_key(32'd1, 32'd0);
        send_message(32'd9);
        wait_drained();

        // Zero modulus acts as 2^32: products keep their low word.
        set_key(32'd0, 32'h8000_0001);
        send_message(32'd3);
        send_message(32'hDEAD_BEEF);
        wait_drained();

        // Writes to the spare indexes must leave the key alone.
        set_key(32'd1000003, 32'd65537);
        write_reg(REG_SPARE_2, 32'hFFFF_FFFF);
        write_reg(REG_SPARE_3, 32'h0000_0000);
        @(posedge clk);
        cfg_write <= 1'b0;
        send_message(32'd2);
        send_message(32'd12345);
        wait_drained();

        // Modulus two with a small exponent.
        set_key(32'd2, 32'd2);
        send_message(32'hFFFF_FFFF);
        send_message(32'd6);
        wait_drained();

        // Random keys and messages; the last keys run without idling.
        for (int k = 0; k < 10; k++)
        begin
            if (k >= 8)
                idling_on = 1'b0;
            run_random_key(26);
        end

        repeat (ITEM_CYCLES) @(posedge clk);
        if (power_q.size() != 0)
            fail_count++;
        $display("Checked %0d result items under %0d key settings,", checked_count, key_count);
        $display("including zero and unit modulus, zero exponent and ignored register indexes.");
        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // Watchdog for a run that never drains.
    initial
    begin
        #30ms;
        $display("Timeout with %0d result items still outstanding.", power_q.size());
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

>>> sim.f
sv/modexp_pkg.sv
sv/modexp_mulmod.sv
sv/modular_exponentiation.sv
verif/tb_top.sv
